/* rtl/core/deq_pkg.sv */
// shared constants and command codes for the double-ended queue
// no dependencies; compiled before the interfaces and the core
package deq_pkg;

  localparam int unsigned DEQ_CAPACITY  = 1024;
  localparam int unsigned DEQ_WORD_BITS = 32;
  localparam int unsigned CMD_BITS      = 3;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_NONE       = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_PUSH_BACK  = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_BACK   = 3'd4
  } cmd_e;

endpackage

/* rtl/core/deq_req_if.sv */
// request channel of the double-ended queue: command and word to push
// depends on deq_pkg
interface deq_req_if import deq_pkg::*; #(
  parameter int unsigned WordBits = DEQ_WORD_BITS
);
  logic                       valid;
  logic                       ready;
  logic [CMD_BITS-1:0]        command;
  logic signed [WordBits-1:0] push_value;

  modport source (output valid, output command, output push_value, input ready);
  modport sink   (input valid, input command, input push_value, output ready);
endinterface

/* rtl/core/deq_rsp_if.sv */
// response channel of the double-ended queue: pop result, flags and queue view
// depends on deq_pkg
interface deq_rsp_if import deq_pkg::*; #(
  parameter int unsigned WordBits = DEQ_WORD_BITS,
  parameter int unsigned CntBits  = $clog2(DEQ_CAPACITY + 1)
);
  logic                       valid;
  logic                       ready;
  logic signed [WordBits-1:0] popped_value;
  logic                       pop_missed;
  logic                       push_dropped;
  logic [CntBits-1:0]         occupancy;
  logic                       is_empty;
  logic signed [WordBits-1:0] front_value;
  logic signed [WordBits-1:0] back_value;

  modport source (output valid, output popped_value, output pop_missed,
                  output push_dropped, output occupancy, output is_empty,
                  output front_value, output back_value, input ready);
  modport sink   (input valid, input popped_value, input pop_missed,
                  input push_dropped, input occupancy, input is_empty,
                  input front_value, input back_value, output ready);
endinterface

/* rtl/core/double_ended_queue.sv */
// bounded double-ended queue of signed words kept in a ring buffer
// depends on deq_pkg, deq_req_if and deq_rsp_if
//
// usage:
// - in_i carries one command per transaction: none (query), push front,
//   push back, pop front or pop back, plus the word to push
// - out_o returns exactly one transaction per command: the popped word
//   (-1 and pop_missed on an empty queue), push_dropped on a full queue,
//   and occupancy, is_empty, front and back as they stand after the command
// - the result of a command is registered and shows in the cycle after it is
//   taken; one command per cycle is sustained while out_o does not stall, set by
//   the single write port and the two registered read ports of the entry store
// - front and back are held in registers; the entries next to them are
//   read from the store into registers in advance, so a pop finds its successor ready
// - reset empties the queue at once (head and count cleared, tail parked
//   one slot behind the head); the store itself is not cleared, only
//   entries inside the occupied span are ever shown
// - when out_o stalls the result register holds and in_i.ready drops, so a
//   new command is taken only in a cycle where the pending result leaves
module double_ended_queue import deq_pkg::*; #(
  parameter int unsigned CAPACITY  = DEQ_CAPACITY,
  parameter int unsigned WORD_BITS = DEQ_WORD_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  deq_req_if.sink   in_i,
  deq_rsp_if.source out_o
);

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CAPACITY - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(CAPACITY);
  localparam logic signed [WORD_BITS-1:0] MinusOne = '1;

  // ring index step with wrap at the capacity
  function automatic logic [IdxW-1:0] idx_inc(input logic [IdxW-1:0] idx);
    return (idx == LastIdx) ? '0 : idx + IdxW'(1);
  endfunction

  function automatic logic [IdxW-1:0] idx_dec(input logic [IdxW-1:0] idx);
    return (idx == '0) ? LastIdx : idx - IdxW'(1);
  endfunction

  // queue state: head points at the front entry, tail at the back entry
  logic [IdxW-1:0] head_q, head_d;
  logic [IdxW-1:0] tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;

  // cached front and back words, and the entries just inside them
  logic signed [WORD_BITS-1:0] front_q, front_d;
  logic signed [WORD_BITS-1:0] back_q, back_d;
  logic signed [WORD_BITS-1:0] second_q;  // entry after the front
  logic signed [WORD_BITS-1:0] penult_q;  // entry before the back

  // entry store: one write port, two registered read ports
  logic signed [WORD_BITS-1:0] mem_q [CAPACITY];
  logic                        mem_we;
  logic [IdxW-1:0]             mem_waddr;
  logic signed [WORD_BITS-1:0] mem_wdata;
  logic [IdxW-1:0]             rd_second;
  logic [IdxW-1:0]             rd_penult;

  // result register
  logic                        out_valid_q;
  logic signed [WORD_BITS-1:0] popped_q, popped_d;
  logic                        missed_q, missed_d;
  logic                        dropped_q, dropped_d;
  logic [CntW-1:0]             occ_q;
  logic                        empty_q;
  logic signed [WORD_BITS-1:0] front_out_q;
  logic signed [WORD_BITS-1:0] back_out_q;

  logic in_fire;
  logic is_empty_d;

  // a new transaction enters whenever the result slot is free or draining
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  // command decode and state update
  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    front_d   = front_q;
    back_d    = back_q;
    mem_we    = 1'b0;
    mem_waddr = head_q;
    mem_wdata = in_i.push_value;
    popped_d  = '0;
    missed_d  = 1'b0;
    dropped_d = 1'b0;
    if (in_fire) begin
      unique case (cmd_e'(in_i.command))
        CMD_PUSH_FRONT: begin
          if (count_q == FullCnt) begin
            dropped_d = 1'b1;
          end else begin
            head_d    = idx_dec(head_q);
            mem_we    = 1'b1;
            mem_waddr = head_d;
            count_d   = count_q + CntW'(1);
            front_d   = in_i.push_value;
            if (count_q == '0) begin
              back_d = in_i.push_value;
            end
          end
        end
        CMD_PUSH_BACK: begin
          if (count_q == FullCnt) begin
            dropped_d = 1'b1;
          end else begin
            tail_d    = idx_inc(tail_q);
            mem_we    = 1'b1;
            mem_waddr = tail_d;
            count_d   = count_q + CntW'(1);
            back_d    = in_i.push_value;
            if (count_q == '0) begin
              front_d = in_i.push_value;
            end
          end
        end
        CMD_POP_FRONT: begin
          if (count_q == '0) begin
            popped_d = MinusOne;
            missed_d = 1'b1;
          end else begin
            popped_d = front_q;
            head_d   = idx_inc(head_q);
            count_d  = count_q - CntW'(1);
            front_d  = second_q;
          end
        end
        CMD_POP_BACK: begin
          if (count_q == '0) begin
            popped_d = MinusOne;
            missed_d = 1'b1;
          end else begin
            popped_d = back_q;
            tail_d   = idx_dec(tail_q);
            count_d  = count_q - CntW'(1);
            back_d   = penult_q;
          end
        end
        default: begin
          // query or unused code: state unchanged
        end
      endcase
    end
  end

  assign is_empty_d = (count_d == '0);

  // prefetch the neighbors of the next front and back
  assign rd_second = idx_inc(head_d);
  assign rd_penult = idx_dec(tail_d);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    // same-cycle write goes straight to the read register
    if (mem_we && (mem_waddr == rd_second)) begin
      second_q <= mem_wdata;
    end else begin
      second_q <= mem_q[rd_second];
    end
    if (mem_we && (mem_waddr == rd_penult)) begin
      penult_q <= mem_wdata;
    end else begin
      penult_q <= mem_q[rd_penult];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= LastIdx;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    front_q <= front_d;
    back_q  <= back_d;
    if (in_fire) begin
      popped_q    <= popped_d;
      missed_q    <= missed_d;
      dropped_q   <= dropped_d;
      occ_q       <= count_d;
      empty_q     <= is_empty_d;
      front_out_q <= is_empty_d ? MinusOne : front_d;
      back_out_q  <= is_empty_d ? MinusOne : back_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.popped_value = popped_q;
  assign out_o.pop_missed   = missed_q;
  assign out_o.push_dropped = dropped_q;
  assign out_o.occupancy    = occ_q;
  assign out_o.is_empty     = empty_q;
  assign out_o.front_value  = front_out_q;
  assign out_o.back_value   = back_out_q;

  // checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("occupancy beyond capacity");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q <= LastIdx) && (tail_q <= LastIdx))
    else $error("ring index out of range");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (count_q != FullCnt) &&
    ((in_i.command == CMD_PUSH_FRONT) || (in_i.command == CMD_PUSH_BACK))
    |=> (count_q - $past(count_q)) == CntW'(1))
    else $error("accepted push did not grow the queue");

  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (count_q == '0) &&
    ((in_i.command == CMD_POP_FRONT) || (in_i.command == CMD_POP_BACK))
    |=> out_valid_q && missed_q && empty_q)
    else $error("pop on empty queue not flagged");

  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted transaction produced no result");

endmodule
